/* rtl/utc2ep_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utc2ep_pkg
// Types, character codes and calendar helpers for the UTCTime converter.
// ----------------------------------------------------------------------------
package utc2ep_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } utc2ep_in_t;

    typedef struct packed {
        logic signed [32:0] epoch_seconds;
        logic [1:0]         status;
    } utc2ep_out_t;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UTC_Z = 8'h5A;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [1:0] ZONE_UTC   = 2'd0;
    localparam logic [1:0] ZONE_PLUS  = 2'd1;
    localparam logic [1:0] ZONE_MINUS = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIGIT   = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;

    localparam logic [4:0] POS_YEAR_LO = 5'd1;
    localparam logic [4:0] POS_MON_LO  = 5'd3;
    localparam logic [4:0] POS_DAY_LO  = 5'd5;
    localparam logic [4:0] POS_HOUR_LO = 5'd7;
    localparam logic [4:0] POS_MIN_LO  = 5'd9;
    localparam logic [4:0] POS_SEC_LO  = 5'd11;
    localparam logic [4:0] POS_ZONE    = 5'd12;
    localparam logic [4:0] POS_OFFH_LO = 5'd14;
    localparam logic [4:0] LEN_UTC     = 5'd13;
    localparam logic [4:0] LEN_OFFSET  = 5'd17;

    localparam logic [6:0] YEAR_PIVOT  = 7'd50;

    // days = 365*z + z/4 + month_start + day - DAYS_BIAS, z = year - 1948
    // (century terms are constant over 1948..2057)
    localparam logic signed [17:0] DAYS_BIAS = 18'sd7977;
    localparam logic signed [32:0] DAY_SECS  = 33'sd86400;

    // whole years contained in a month count (0..9 over the valid range)
    function automatic logic [3:0] years_of(input logic [7:0] t);
        logic [3:0] q;
        q = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (t >= 8'(12 * k)) q = 4'(k);
        end
        return q;
    endfunction

    // days before the start of a March-based month
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

/* rtl/utctime_to_epoch_seconds.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utctime_to_epoch_seconds
// Parses a UTCTime string one character per item and returns signed Unix
// seconds plus a status on the character marked last.
// ----------------------------------------------------------------------------
//  channel | dir | payload                       | result
//  s_      | in  | char_code, last_char          | one char per item
//  m_      | out | epoch_seconds, status         | one per last char
//
//  One item per cycle sustained while the output is not stalled. A result
//  passes field capture, day count and time-of-day terms, then the final
//  multiply by seconds per day. Reset clears the parser and all stage
//  valids. Each stage holds when the one after it is full and stalled;
//  input is stalled only when the capture stage is full and cannot move on.
module utctime_to_epoch_seconds (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  wire utc2ep_pkg::utc2ep_in_t s_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output utc2ep_pkg::utc2ep_out_t m_data
);
    import utc2ep_pkg::*;

    // parser state
    logic [4:0] char_position_reg, char_position_next;
    logic [3:0] tens_digit_reg, tens_digit_next;
    logic [6:0] year_reg, year_next;
    logic [6:0] month_reg, month_next;
    logic [6:0] day_reg, day_next;
    logic [6:0] hour_reg, hour_next;
    logic [6:0] minute_reg, minute_next;
    logic [6:0] second_reg, second_next;
    logic [1:0] zone_reg, zone_next;
    logic [6:0] offh_reg, offh_next;
    logic [6:0] offm_reg, offm_next;
    logic       digit_err_reg, digit_err_next;

    // capture stage
    logic       v2_reg;
    logic [6:0] c_year_reg, c_month_reg, c_day_reg, c_hour_reg;
    logic [6:0] c_minute_reg, c_second_reg, c_offh_reg, c_offm_reg;
    logic [1:0] c_zone_reg, c_status_reg, c_status_next;

    // day count stage
    logic                v3_reg;
    logic signed [17:0]  days_reg, days_next;
    logic [18:0]         hms_reg, hms_next;
    logic signed [19:0]  adj_reg, adj_next;
    logic [1:0]          d_status_reg;

    // output register
    logic                m_valid_reg;
    utc2ep_out_t         m_data_reg, m_data_next;

    logic in_acc, ld3, ld4, r2, r3;

    assign ld4     = v3_reg && (!m_valid_reg || m_ready);
    assign r3      = !v3_reg || !m_valid_reg || m_ready;
    assign ld3     = v2_reg && r3;
    assign r2      = !v2_reg || r3;
    assign s_ready = r2;
    assign in_acc  = s_valid && r2;

    // ---------------- character parser ----------------
    logic [4:0] needed;
    logic [3:0] dv;
    logic [7:0] pair;
    logic       is_tens;

    always_comb begin
        char_position_next = char_position_reg;
        tens_digit_next    = tens_digit_reg;
        year_next          = year_reg;
        month_next         = month_reg;
        day_next           = day_reg;
        hour_next          = hour_reg;
        minute_next        = minute_reg;
        second_next        = second_reg;
        zone_next          = zone_reg;
        offh_next          = offh_reg;
        offm_next          = offm_reg;
        digit_err_next     = digit_err_reg;

        needed  = (char_position_reg > POS_ZONE && zone_reg != ZONE_UTC) ? LEN_OFFSET
                                                                         : LEN_UTC;
        dv      = 4'(s_data.char_code - CHAR_ZERO);
        pair    = 8'(tens_digit_reg * 4'd10) + 8'(dv);
        is_tens = (char_position_reg < POS_ZONE) ? !char_position_reg[0]
                                                 : char_position_reg[0];

        if (char_position_reg < needed) begin
            if (char_position_reg == POS_ZONE) begin
                if (s_data.char_code == CHAR_UTC_Z) zone_next = ZONE_UTC;
                else if (s_data.char_code == CHAR_MINUS) zone_next = ZONE_MINUS;
                else zone_next = ZONE_PLUS;
            end else begin
                if (s_data.char_code < CHAR_ZERO || s_data.char_code > CHAR_NINE) begin
                    digit_err_next = 1'b1;
                end
                if (is_tens) begin
                    tens_digit_next = dv;
                end else begin
                    case (char_position_reg)
                        POS_YEAR_LO: year_next   = pair[6:0];
                        POS_MON_LO:  month_next  = pair[6:0];
                        POS_DAY_LO:  day_next    = pair[6:0];
                        POS_HOUR_LO: hour_next   = pair[6:0];
                        POS_MIN_LO:  minute_next = pair[6:0];
                        POS_SEC_LO:  second_next = pair[6:0];
                        POS_OFFH_LO: offh_next   = pair[6:0];
                        default:     offm_next   = pair[6:0];
                    endcase
                end
            end
            char_position_next = char_position_reg + 5'd1;
        end

        if (char_position_next < LEN_UTC
            || (zone_next != ZONE_UTC && char_position_next < LEN_OFFSET)) begin
            c_status_next = ST_SHORT;
        end else if (digit_err_next) begin
            c_status_next = ST_DIGIT;
        end else begin
            c_status_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_position_reg <= '0;
            tens_digit_reg    <= '0;
            year_reg          <= '0;
            month_reg         <= '0;
            day_reg           <= '0;
            hour_reg          <= '0;
            minute_reg        <= '0;
            second_reg        <= '0;
            zone_reg          <= ZONE_UTC;
            offh_reg          <= '0;
            offm_reg          <= '0;
            digit_err_reg     <= 1'b0;
        end else if (in_acc) begin
            if (s_data.last_char) begin
                char_position_reg <= '0;
                tens_digit_reg    <= '0;
                year_reg          <= '0;
                month_reg         <= '0;
                day_reg           <= '0;
                hour_reg          <= '0;
                minute_reg        <= '0;
                second_reg        <= '0;
                zone_reg          <= ZONE_UTC;
                offh_reg          <= '0;
                offm_reg          <= '0;
                digit_err_reg     <= 1'b0;
            end else begin
                char_position_reg <= char_position_next;
                tens_digit_reg    <= tens_digit_next;
                year_reg          <= year_next;
                month_reg         <= month_next;
                day_reg           <= day_next;
                hour_reg          <= hour_next;
                minute_reg        <= minute_next;
                second_reg        <= second_next;
                zone_reg          <= zone_next;
                offh_reg          <= offh_next;
                offm_reg          <= offm_next;
                digit_err_reg     <= digit_err_next;
            end
        end
    end

    // ---------------- capture stage ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (in_acc && s_data.last_char) begin
            v2_reg <= 1'b1;
        end else if (ld3) begin
            v2_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && s_data.last_char) begin
            c_year_reg   <= year_next;
            c_month_reg  <= month_next;
            c_day_reg    <= day_next;
            c_hour_reg   <= hour_next;
            c_minute_reg <= minute_next;
            c_second_reg <= second_next;
            c_zone_reg   <= zone_next;
            c_offh_reg   <= offh_next;
            c_offm_reg   <= offm_next;
            c_status_reg <= c_status_next;
        end
    end

    // ---------------- day count and time of day ----------------
    logic [7:0]  yidx, mon_t, zyear;
    logic [3:0]  q, r, mp;
    logic [16:0] day_sum;
    logic [18:0] off_secs;

    always_comb begin
        yidx  = (c_year_reg < YEAR_PIVOT) ? 8'(c_year_reg) + 8'd100 : 8'(c_year_reg);
        mon_t = 8'(c_month_reg) + 8'd11;
        q     = years_of(mon_t);
        r     = 4'(mon_t - 8'(q * 4'd12));
        mp    = (r >= 4'd2) ? r - 4'd2 : r + 4'd10;
        zyear = yidx + 8'(q) - 8'd49 - ((r < 4'd2) ? 8'd1 : 8'd0);

        day_sum = 17'(zyear * 9'd365) + 17'(zyear[7:2]) + 17'(month_start(mp))
                + 17'(c_day_reg);
        days_next = $signed({1'b0, day_sum}) - DAYS_BIAS;

        hms_next = 19'(c_hour_reg * 12'd3600) + 19'(c_minute_reg * 6'd60)
                 + 19'(c_second_reg);
        off_secs = 19'(c_offh_reg * 12'd3600) + 19'(c_offm_reg * 6'd60);

        case (c_zone_reg)
            ZONE_PLUS:  adj_next = -$signed({1'b0, off_secs});
            ZONE_MINUS: adj_next = $signed({1'b0, off_secs});
            default:    adj_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (ld3) begin
            v3_reg <= 1'b1;
        end else if (ld4) begin
            v3_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld3) begin
            days_reg     <= days_next;
            hms_reg      <= hms_next;
            adj_reg      <= adj_next;
            d_status_reg <= c_status_reg;
        end
    end

    // ---------------- final sum ----------------
    always_comb begin
        m_data_next.status = d_status_reg;
        if (d_status_reg == ST_OK) begin
            m_data_next.epoch_seconds = 33'(days_reg) * DAY_SECS
                                      + $signed({14'd0, hms_reg})
                                      + 33'(adj_reg);
        end else begin
            m_data_next.epoch_seconds = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ld4) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld4) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- assertions ----------------
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_OK || m_data.epoch_seconds == 33'sd0))
        else $error("error status with nonzero seconds");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        char_position_reg <= LEN_OFFSET)
        else $error("character position out of range");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.last_char)
            |=> (char_position_reg == 5'd0 && !digit_err_reg && v2_reg))
        else $error("parser not cleared after last item");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v2_reg && v3_reg && m_valid_reg && !m_ready))
        else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire
